// ===== hdl/bis_pkg.sv =====
// ----------------------------------------------------------------------------
// bis_pkg: shared types and constants for the bounded identifier set
// Request and response payloads, per-cell control, sizing constants.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int CAPACITY = 16;
  localparam int ID_BITS  = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [ID_BITS-1:0] NO_ID = {ID_BITS{1'b1}};

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_FIND = 2'd2,
    OP_READ = 2'd3
  } op_e;

  typedef struct packed {
    op_e         opcode;
    logic [31:0] ident;
    logic [3:0]  slot;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] ident_out;
    logic [4:0]  count;
  } rsp_t;

  typedef struct packed {
    logic add_en;
    logic del_en;
  } cell_ctl_t;

endpackage

// ===== hdl/bis_cell.sv =====
// ----------------------------------------------------------------------------
// bis_cell: one storage cell of the identifier chain
// Holds one entry, compares it to the request id, passes the match chain
// upward and on delete takes the entry of its upper neighbor.
// ----------------------------------------------------------------------------
module bis_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bis_pkg::cell_ctl_t           ctl_i,
  input  logic                         wr_sel_i,
  input  logic [bis_pkg::ID_BITS-1:0]  id_i,
  input  logic [bis_pkg::ID_BITS-1:0]  upper_i,
  input  logic                         hit_below_i,
  output logic                         hit_chain_o,
  output logic [bis_pkg::ID_BITS-1:0]  entry_o
);

  logic [bis_pkg::ID_BITS-1:0] entry_q, entry_d;
  logic                        hit;

  assign hit         = (entry_q == id_i);
  assign hit_chain_o = hit_below_i | hit;
  assign entry_o     = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.add_en && wr_sel_i) begin
      entry_d = id_i;
    end else if (ctl_i.del_en && hit_chain_o) begin
      entry_d = upper_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= bis_pkg::NO_ID;
    end else begin
      entry_q <= entry_d;
    end
  end

endmodule

// ===== hdl/bounded_id_set.sv =====
// ----------------------------------------------------------------------------
// bounded_id_set: fixed-capacity identifier set in a chain of cells
// A request taken in idle is registered; all cells compare and shift in the
// execute state, and the response follows with done_o high in the cycle after
// it. busy is high in execute, when start is ignored. The receiver cannot
// stall. Reset clears the count and sets every entry to no-id at once.
// ----------------------------------------------------------------------------
module bounded_id_set (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  bis_pkg::req_t req_i,
  output logic          done_o,
  output bis_pkg::rsp_t rsp_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                      state_q;
  bis_pkg::req_t               req_q;
  logic [bis_pkg::CNT_W-1:0]   fill_q, fill_d;
  logic                        done_q;
  bis_pkg::rsp_t               rsp_q, rsp_d;

  logic [bis_pkg::ID_BITS-1:0] id;
  logic                        id_valid;
  logic                        found;
  logic                        add_ok, del_ok, find_ok, read_ok;
  logic [bis_pkg::ID_BITS-1:0] rd_data;
  bis_pkg::cell_ctl_t          ctl;

  logic [bis_pkg::CAPACITY:0]     hit_chain;
  logic [bis_pkg::CAPACITY-1:0]   wr_sel;
  logic [bis_pkg::ID_BITS-1:0]    entry [bis_pkg::CAPACITY];
  logic [bis_pkg::ID_BITS-1:0]    upper [bis_pkg::CAPACITY];

  assign id        = req_q.ident[bis_pkg::ID_BITS-1:0];
  assign id_valid  = (id != bis_pkg::NO_ID);
  assign found     = hit_chain[bis_pkg::CAPACITY];
  assign hit_chain[0] = 1'b0;

  assign add_ok  = (state_q == ST_EXEC) && (req_q.opcode == bis_pkg::OP_ADD) && id_valid
                   && (int'(fill_q) < bis_pkg::CAPACITY) && !found;
  assign del_ok  = (state_q == ST_EXEC) && (req_q.opcode == bis_pkg::OP_DEL) && id_valid
                   && found;
  assign find_ok = (req_q.opcode == bis_pkg::OP_FIND) && id_valid && found;
  assign read_ok = (req_q.opcode == bis_pkg::OP_READ) && (int'(req_q.slot) < int'(fill_q));

  assign ctl.add_en = add_ok;
  assign ctl.del_en = del_ok;

  for (genvar i = 0; i < bis_pkg::CAPACITY; i++) begin : g_cell
    assign wr_sel[i] = (int'(fill_q) == i);
    if (i == bis_pkg::CAPACITY - 1) begin : g_top
      assign upper[i] = bis_pkg::NO_ID;
    end else begin : g_mid
      assign upper[i] = entry[i+1];
    end

    bis_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .wr_sel_i    (wr_sel[i]),
      .id_i        (id),
      .upper_i     (upper[i]),
      .hit_below_i (hit_chain[i]),
      .hit_chain_o (hit_chain[i+1]),
      .entry_o     (entry[i])
    );
  end

  always_comb begin
    rd_data = bis_pkg::NO_ID;
    for (int i = 0; i < bis_pkg::CAPACITY; i++) begin
      if (int'(req_q.slot) == i) begin
        rd_data = entry[i];
      end
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (add_ok) begin
      fill_d = fill_q + 1'b1;
    end else if (del_ok) begin
      fill_d = fill_q - 1'b1;
    end
    rsp_d.ok        = add_ok | del_ok | find_ok | read_ok;
    rsp_d.ident_out = read_ok ? rd_data[31:0] : 32'hFFFF_FFFF;
    rsp_d.count     = 5'(fill_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          fill_q  <= fill_d;
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && (state_q == ST_IDLE)) begin
      req_q <= req_i;
    end
    if (state_q == ST_EXEC) begin
      rsp_q <= rsp_d;
    end
  end

  assign busy   = (state_q == ST_EXEC);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_accept_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not enter execute");

  a_exec_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (done_o && !busy))
    else $error("execute cycle did not produce a response");

  a_fill_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(fill_q) <= bis_pkg::CAPACITY)
    else $error("fill count beyond capacity");

  a_fill_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy) |=> $stable(fill_q))
    else $error("fill count changed outside execute");

endmodule
